>>> hdl/vlmm_pkg.sv
// Package for the variable-length message mailbox: sizes, operation and
// status codes, transfer payload structs and the ring memory port structs.
// No dependencies.
package vlmm_pkg;

    localparam int STORE_WORDS       = 512;
    localparam int MAX_MESSAGE_WORDS = 63;

    localparam int IDX_W  = $clog2(STORE_WORDS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int FILL_W = $clog2(MAX_MESSAGE_WORDS + 1);

    localparam int LEN_W  = 9;
    localparam int SND_W  = 5;
    localparam int WORD_W = 64;
    // A record of up to 511 bytes has at most 64 data words plus its header.
    localparam int DW_W   = LEN_W - 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORDS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BYTES = 2'd2;

    localparam logic [9:0] WORDS_RESET     = 10'd512;
    localparam logic [8:0] MIN_BYTES_RESET = 9'd8;

    typedef enum logic [1:0] {
        OP_SEND_HEAD,
        OP_SEND_DATA,
        OP_RECEIVE,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_NO_ROOM,
        ST_TOO_SHORT,
        ST_EMPTY,
        ST_LIMIT_SMALL,
        ST_NO_SEND,
        ST_NO_MAILBOX
    } status_t;

    typedef struct packed {
        op_t                 operation;
        logic [SND_W-1:0]    sender_id;
        logic [LEN_W-1:0]    message_bytes;
        logic [WORD_W-1:0]   data_word;
        logic [LEN_W-1:0]    receive_limit;
    } req_t;

    typedef struct packed {
        status_t             status;
        logic [SND_W-1:0]    out_sender;
        logic [LEN_W-1:0]    out_length;
        logic [WORD_W-1:0]   out_word;
        logic                last;
    } rsp_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [WORD_W-1:0]   data;
    } ram_wr_t;

    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
    } ram_rd_t;

endpackage

>>> hdl/variable_length_message_mailbox.sv
// Top level of the variable-length message mailbox: control sequencer,
// ring bookkeeping and output register. Depends on vlmm_pkg and vlmm_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------
//  request   | req_valid / req_stall  | req_payload (vlmm_pkg::req_t)
//  response  | rsp_valid / rsp_stall  | rsp_payload (vlmm_pkg::rsp_t)
//  config    | cfg_write              | cfg_index, cfg_data
//
// One request at a time: a send header, a send data word, a receive on an
// empty ring and a receive refused for its limit give one response each; a
// successful receive its header and data, one response per cycle unless stalled.
// Reset leaves the mailbox disabled and empty; the ring needs no clearing.
// A stalled response holds in the output register while the next request
// is taken, and the sequencer waits until that register is free.
module variable_length_message_mailbox (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [vlmm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vlmm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  vlmm_pkg::req_t                    req_payload,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output vlmm_pkg::rsp_t                    rsp_payload
);
    import vlmm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RX_HEAD,
        S_RX_DATA
    } state_t;

    state_t             state_reg, state_next;
    req_t               item_reg, item_next;
    logic               enabled_reg, enabled_next;
    logic [9:0]         words_reg, words_next;
    logic [8:0]         min_bytes_reg, min_bytes_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [CNT_W-1:0]   committed_reg, committed_next;
    logic [CNT_W-1:0]   reserved_reg, reserved_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [LEN_W-1:0]   mlen_reg, mlen_next;
    logic [DW_W-1:0]    rec_reg, rec_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic [CNT_W-1:0]   ring_n;
    logic [CNT_W-1:0]   free_words;
    logic [IDX_W-1:0]   base_wr;
    logic [DW_W-1:0]    hdr_dw;
    logic [DW_W-1:0]    hdr_rec;
    logic [LEN_W-1:0]   rx_len;
    logic [SND_W-1:0]   rx_snd;
    logic [DW_W-1:0]    rx_rec;
    logic [WORD_W-1:0]  data_mask;
    logic               out_free;
    ram_wr_t            ram_wr;
    ram_rd_t            ram_rd;
    logic [WORD_W-1:0]  ram_q;

    function automatic logic [IDX_W-1:0] adv(
        input logic [IDX_W-1:0] idx,
        input logic [CNT_W-1:0] by,
        input logic [CNT_W-1:0] n
    );
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(idx) + (CNT_W+1)'(by);
        if (s >= (CNT_W+1)'(n))
        begin
            s = s - (CNT_W+1)'(n);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic rsp_t make_rsp(
        input status_t            st,
        input logic [SND_W-1:0]   snd,
        input logic [LEN_W-1:0]   len,
        input logic [WORD_W-1:0]  word,
        input logic               lst
    );
        rsp_t r;
        r.status     = st;
        r.out_sender = snd;
        r.out_length = len;
        r.out_word   = word;
        r.last       = lst;
        return r;
    endfunction

    vlmm_ram u_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd      (ram_rd),
        .rd_data (ram_q)
    );

    always_comb
    begin
        if (words_reg < 10'd2)
        begin
            ring_n = CNT_W'(2);
        end
        else if (32'(words_reg) > STORE_WORDS)
        begin
            ring_n = CNT_W'(STORE_WORDS);
        end
        else
        begin
            ring_n = CNT_W'(words_reg);
        end
    end

    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign free_words = ring_n - committed_reg;
    // A new header always starts right after the committed records.
    assign base_wr    = adv(rd_idx_reg, committed_reg, ring_n);
    assign hdr_dw     = DW_W'((10'(item_reg.message_bytes) + 10'd7) >> 3);
    assign hdr_rec    = hdr_dw + DW_W'(1);
    assign rx_len     = ram_q[LEN_W-1:0];
    assign rx_snd     = ram_q[16 +: SND_W];
    assign rx_rec     = DW_W'((10'(rx_len) + 10'd7) >> 3) + DW_W'(1);
    assign data_mask  = (rem_reg < 9'd8) ?
                        ~({WORD_W{1'b1}} << {rem_reg[2:0], 3'b000}) : {WORD_W{1'b1}};

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        enabled_next   = enabled_reg;
        words_next     = words_reg;
        min_bytes_next = min_bytes_reg;
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        committed_next = committed_reg;
        reserved_next  = reserved_reg;
        fill_next      = fill_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        mlen_next      = mlen_reg;
        rec_next       = rec_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_wr         = '0;
        ram_rd         = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next  = req_payload;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                if (item_reg.operation == OP_NONE)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = make_rsp(ST_OK, '0, '0, '0, 1'b1);
                    if (!enabled_reg)
                    begin
                        rsp_next.status = ST_NO_MAILBOX;
                    end
                    else
                    begin
                        case (item_reg.operation)
                            OP_SEND_HEAD:
                            begin
                                // Any open reservation is dropped first.
                                reserved_next = '0;
                                fill_next     = '0;
                                wr_idx_next   = base_wr;
                                if (item_reg.message_bytes < min_bytes_reg)
                                begin
                                    rsp_next.status = ST_TOO_SHORT;
                                end
                                else if (hdr_dw > DW_W'(MAX_MESSAGE_WORDS) ||
                                         32'(hdr_rec) > 32'(free_words))
                                begin
                                    rsp_next.status = ST_NO_ROOM;
                                end
                                else
                                begin
                                    ram_wr.en   = 1'b1;
                                    ram_wr.addr = base_wr;
                                    ram_wr.data = {43'd0, item_reg.sender_id, 7'd0,
                                                   item_reg.message_bytes};
                                    wr_idx_next = adv(base_wr, CNT_W'(1), ring_n);
                                    if (hdr_dw == '0)
                                    begin
                                        committed_next = committed_reg + CNT_W'(1);
                                    end
                                    else
                                    begin
                                        reserved_next = CNT_W'(hdr_rec);
                                        fill_next     = FILL_W'(hdr_dw);
                                    end
                                end
                            end

                            OP_SEND_DATA:
                            begin
                                if (fill_reg == '0)
                                begin
                                    rsp_next.status = ST_NO_SEND;
                                end
                                else
                                begin
                                    ram_wr.en   = 1'b1;
                                    ram_wr.addr = wr_idx_reg;
                                    ram_wr.data = item_reg.data_word;
                                    wr_idx_next = adv(wr_idx_reg, CNT_W'(1), ring_n);
                                    fill_next   = fill_reg - FILL_W'(1);
                                    // The final data word makes the record visible.
                                    if (fill_reg == FILL_W'(1))
                                    begin
                                        committed_next = committed_reg + reserved_reg;
                                        reserved_next  = '0;
                                    end
                                end
                            end

                            OP_RECEIVE:
                            begin
                                if (committed_reg == '0)
                                begin
                                    rsp_next.status = ST_EMPTY;
                                end
                                else
                                begin
                                    // Fetch the header word; nothing is sent yet.
                                    rsp_valid_next = rsp_valid_reg && rsp_stall;
                                    rsp_next       = rsp_reg;
                                    ram_rd.en      = 1'b1;
                                    ram_rd.addr    = rd_idx_reg;
                                    state_next     = S_RX_HEAD;
                                end
                            end

                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end

            S_RX_HEAD:
            begin
                // The read data register holds the header until it is consumed.
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (item_reg.receive_limit < rx_len)
                    begin
                        rsp_next   = make_rsp(ST_LIMIT_SMALL, '0, '0, '0, 1'b1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rsp_next  = make_rsp(ST_OK, rx_snd, rx_len, '0, rx_len == '0);
                        mlen_next = rx_len;
                        rem_next  = rx_len;
                        rec_next  = rx_rec;
                        if (rx_len == '0)
                        begin
                            rd_idx_next    = adv(rd_idx_reg, CNT_W'(1), ring_n);
                            committed_next = committed_reg - CNT_W'(1);
                            state_next     = S_IDLE;
                        end
                        else
                        begin
                            ptr_next    = adv(rd_idx_reg, CNT_W'(1), ring_n);
                            ram_rd.en   = 1'b1;
                            ram_rd.addr = ptr_next;
                            state_next  = S_RX_DATA;
                        end
                    end
                end
            end

            S_RX_DATA:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = make_rsp(ST_OK, '0, mlen_reg, ram_q & data_mask,
                                              rem_reg <= 9'd8);
                    ptr_next       = adv(ptr_reg, CNT_W'(1), ring_n);
                    if (rem_reg <= 9'd8)
                    begin
                        rd_idx_next    = ptr_next;
                        committed_next = committed_reg - CNT_W'(rec_reg);
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        rem_next    = rem_reg - 9'd8;
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = ptr_next;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // The user must write only while the block is idle; the block does not enforce it.
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENABLED:
                begin
                    enabled_next = cfg_data[0];
                end
                CFG_WORDS:
                begin
                    words_next = cfg_data[9:0];
                end
                CFG_MIN_BYTES:
                begin
                    min_bytes_next = cfg_data[8:0];
                end
                default:
                begin
                    min_bytes_next = min_bytes_reg;
                end
            endcase
            if (cfg_index == CFG_ENABLED || cfg_index == CFG_WORDS)
            begin
                rd_idx_next    = '0;
                wr_idx_next    = '0;
                committed_next = '0;
                reserved_next  = '0;
                fill_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            item_reg      <= '0;
            enabled_reg   <= 1'b0;
            words_reg     <= WORDS_RESET;
            min_bytes_reg <= MIN_BYTES_RESET;
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            committed_reg <= '0;
            reserved_reg  <= '0;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            mlen_reg      <= '0;
            rec_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            enabled_reg   <= enabled_next;
            words_reg     <= words_next;
            min_bytes_reg <= min_bytes_next;
            rd_idx_reg    <= rd_idx_next;
            wr_idx_reg    <= wr_idx_next;
            committed_reg <= committed_next;
            reserved_reg  <= reserved_next;
            fill_reg      <= fill_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            mlen_reg      <= mlen_next;
            rec_reg       <= rec_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

`ifndef SYNTH
    // Committed and reserved words never exceed the ring.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        ((CNT_W+1)'(committed_reg) + (CNT_W+1)'(reserved_reg)) <= (CNT_W+1)'(ring_n))
        else $error("ring occupancy exceeds ring size");

    // An open send has both a reservation and words still to fill.
    a_open_send: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) == (reserved_reg == '0))
        else $error("reservation and fill count disagree");

    // Streaming a message needs a committed record behind it.
    a_rx_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RX_DATA || state_reg == S_RX_HEAD) |-> committed_reg != '0)
        else $error("receive in progress on an empty ring");

    // Ring indices stay inside the ring in use.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W'(rd_idx_reg) < ring_n) && (CNT_W'(wr_idx_reg) < ring_n))
        else $error("ring index outside the ring");

    // A response transfer that was stalled is still offered next cycle.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("stalled response was lost or changed");
`endif

endmodule

>>> hdl/vlmm_ram.sv
// Ring store of the mailbox: one write port and one registered read port.
// Depends on vlmm_pkg.
module vlmm_ram (
    input  logic                    clk,
    input  vlmm_pkg::ram_wr_t       wr,
    input  vlmm_pkg::ram_rd_t       rd,
    output logic [vlmm_pkg::WORD_W-1:0] rd_data
);
    import vlmm_pkg::*;

    // Contents are undefined until written; only committed records are read.
    logic [WORD_W-1:0] mem [STORE_WORDS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule
